// ===== src/crc8_register_access_requester_assert.svh =====
// Assertion macros used by the requester back end (crq_back).
// Expects signals named clk and arst_n in the including module.
`ifndef CRC8_REGISTER_ACCESS_REQUESTER_ASSERT_SVH
`define CRC8_REGISTER_ACCESS_REQUESTER_ASSERT_SVH

// same-cycle implication
`define CRQ_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CRQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/crq_pkg.sv =====
// Shared types, constants and the CRC-8 byte step for the register access requester.
// No dependencies.
package crq_pkg;

	localparam int MAX_WORDS = 16;
	localparam int CNT_W     = $clog2(MAX_WORDS + 1);
	localparam int WIDX_W    = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
	localparam int POS_W     = $clog2(2 * MAX_WORDS + 6);
	localparam int FRAME_LEN = 5;
	localparam int FIDX_W    = $clog2(FRAME_LEN + 1);
	localparam int QDEPTH    = 2;
	localparam int QPTR_W    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W    = $clog2(QDEPTH + 1);

	localparam logic [7:0]  CMD_READ      = 8'h03;
	localparam logic [7:0]  CMD_WRITE     = 8'h01;
	localparam logic [7:0]  CRC_POLY      = 8'h8C;
	localparam logic [15:0] TIMEOUT_RESET = 16'd100;
	localparam logic [15:0] RETRY_RESET   = 16'd10;

	typedef enum logic [1:0] {
		KIND_READ  = 2'd0,
		KIND_WRITE = 2'd1,
		KIND_RX    = 2'd2,
		KIND_TICK  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		RES_TX      = 2'd0,
		RES_WORD    = 2'd1,
		RES_DONE    = 2'd2,
		RES_RESTART = 2'd3
	} res_kind_t;

	typedef enum logic [1:0] {
		REG_RESPONSE_TIMEOUT = 2'd0,
		REG_RETRY_LIMIT      = 2'd1
	} cfg_reg_t;

	typedef struct packed {
		kind_t             kind;
		logic [15:0]       addr;
		logic [CNT_W-1:0]  cnt;
		logic [15:0]       wval;
		logic [7:0]        rxb;
	} cmd_t;

	// reflected CRC-8, one byte, LSB first
	function automatic logic [7:0] crc8_step(input logic [7:0] crc_in, input logic [7:0] b_in);
		logic [7:0] c;
		logic [7:0] b;
		c = crc_in;
		b = b_in;
		for (int i = 0; i < 8; i++) begin
			if (c[0] ^ b[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
			b = b >> 1;
		end
		return c;
	endfunction

endpackage

// ===== src/crq_front.sv =====
// Front end: accepts input items, clamps the read count, queues decoded commands.
// Depends on crq_pkg.
module crq_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         in_kind,
	input  logic [15:0]        in_addr,
	input  logic [15:0]        in_count,
	input  logic [15:0]        in_wval,
	input  logic [7:0]         in_rxb,
	output logic               cmd_valid,
	output crq_pkg::cmd_t      cmd,
	input  logic               cmd_pop
);

	crq_pkg::cmd_t                 q_mem [crq_pkg::QDEPTH];
	logic [crq_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [crq_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [crq_pkg::QCNT_W-1:0]    fill_q;
	crq_pkg::cmd_t                 dec;
	logic                          push;

	always_comb begin
		dec.kind = crq_pkg::kind_t'(in_kind);
		dec.addr = in_addr;
		dec.wval = in_wval;
		dec.rxb  = in_rxb;
		dec.cnt  = '0;
		if (dec.kind == crq_pkg::KIND_READ) begin
			if (in_count > 16'(crq_pkg::MAX_WORDS)) begin
				dec.cnt = crq_pkg::CNT_W'(crq_pkg::MAX_WORDS);
			end else begin
				dec.cnt = in_count[crq_pkg::CNT_W-1:0];
			end
		end
	end

	assign in_ready  = (fill_q != crq_pkg::QCNT_W'(crq_pkg::QDEPTH));
	assign push      = in_valid && in_ready;
	assign cmd_valid = (fill_q != '0);
	assign cmd       = q_mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_ptr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == crq_pkg::QPTR_W'(crq_pkg::QDEPTH - 1)) ? '0 :
					wr_ptr_q + crq_pkg::QPTR_W'(1);
			end
			if (cmd_pop) begin
				rd_ptr_q <= (rd_ptr_q == crq_pkg::QPTR_W'(crq_pkg::QDEPTH - 1)) ? '0 :
					rd_ptr_q + crq_pkg::QPTR_W'(1);
			end
			if (push && !cmd_pop) begin
				fill_q <= fill_q + crq_pkg::QCNT_W'(1);
			end else if (!push && cmd_pop) begin
				fill_q <= fill_q - crq_pkg::QCNT_W'(1);
			end
		end
	end

endmodule

// ===== src/crq_back.sv =====
// Back end: request framing, response checking, retries and the output register.
// Depends on crq_pkg and crc8_register_access_requester_assert.svh.
`include "crc8_register_access_requester_assert.svh"

module crq_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cmd_valid,
	input  crq_pkg::cmd_t           cmd,
	output logic                    cmd_pop,
	input  logic [15:0]             response_timeout,
	input  logic [15:0]             retry_limit,
	output logic                    out_valid,
	input  logic                    out_ready,
	output crq_pkg::res_kind_t      out_kind,
	output logic [7:0]              out_tx,
	output logic [15:0]             out_word,
	output logic [3:0]              out_index,
	output logic                    out_last
);

	typedef enum logic [4:0] {
		ST_IDLE    = 5'b00001,
		ST_SEND    = 5'b00010,
		ST_RESTART = 5'b00100,
		ST_WORDS   = 5'b01000,
		ST_DONE    = 5'b10000
	} state_t;

	state_t                         state_q;
	logic                           awaiting_q;
	logic                           is_read_q;
	logic [7:0]                     frame_q [crq_pkg::FRAME_LEN];
	logic [crq_pkg::CNT_W-1:0]      cnt_q;
	logic [crq_pkg::POS_W-1:0]      rx_pos_q;
	logic [7:0]                     rx_crc_q;
	logic                           echo_q;
	logic [7:0]                     low_q;
	logic [15:0]                    store_q [crq_pkg::MAX_WORDS];
	logic [15:0]                    failed_q;
	logic [15:0]                    wait_q;
	logic [crq_pkg::FIDX_W-1:0]     fidx_q;
	logic [crq_pkg::WIDX_W-1:0]     widx_q;
	logic [7:0]                     tx_crc_q;

	logic                           out_valid_q;
	crq_pkg::res_kind_t             out_kind_q;
	logic [7:0]                     out_tx_q;
	logic [15:0]                    out_word_q;
	logic [3:0]                     out_index_q;
	logic                           out_last_q;

	logic                           out_free;
	logic [crq_pkg::POS_W-1:0]      total;
	logic [crq_pkg::POS_W-1:0]      pos_inc;
	logic [crq_pkg::POS_W-1:0]      pos_m4;
	logic [crq_pkg::WIDX_W-1:0]     wsel;
	logic                           last_byte;
	logic [15:0]                    wait_inc;
	logic [15:0]                    failed_inc;
	logic                           over_limit;
	logic [7:0]                     frame_byte;
	logic                           store_we;
	logic                           is_req;
	logic                           rx_go;
	logic                           tick_go;
	logic                           fail_go;
	logic                           words_end;

	logic                           emit;
	crq_pkg::res_kind_t             e_kind;
	logic [7:0]                     e_tx;
	logic [15:0]                    e_word;
	logic [3:0]                     e_idx;
	logic                           e_last;

	assign out_free   = !out_valid_q || out_ready;
	assign total      = is_read_q ?
		(crq_pkg::POS_W'(5) + (crq_pkg::POS_W'(cnt_q) << 1)) : crq_pkg::POS_W'(6);
	assign pos_inc    = rx_pos_q + crq_pkg::POS_W'(1);
	assign pos_m4     = rx_pos_q - crq_pkg::POS_W'(4);
	assign wsel       = pos_m4[crq_pkg::WIDX_W:1];
	assign last_byte  = !(pos_inc < total);
	assign wait_inc   = wait_q + 16'd1;
	assign failed_inc = failed_q + 16'd1;
	assign over_limit = failed_inc > retry_limit;
	assign words_end  = (crq_pkg::CNT_W'(widx_q) + crq_pkg::CNT_W'(1)) == cnt_q;

	assign cmd_pop = (state_q == ST_IDLE) && cmd_valid;
	assign is_req  = cmd_pop &&
		(cmd.kind == crq_pkg::KIND_READ || cmd.kind == crq_pkg::KIND_WRITE);
	assign rx_go   = cmd_pop && awaiting_q && cmd.kind == crq_pkg::KIND_RX;
	assign tick_go = cmd_pop && awaiting_q && cmd.kind == crq_pkg::KIND_TICK;
	assign fail_go = (tick_go && !(wait_inc < response_timeout)) ||
		(rx_go && last_byte && !(echo_q && rx_crc_q == cmd.rxb));
	assign store_we = rx_go && !last_byte && is_read_q &&
		!(rx_pos_q < crq_pkg::POS_W'(4)) && rx_pos_q[0];

	always_comb begin
		frame_byte = tx_crc_q;
		if (fidx_q != crq_pkg::FIDX_W'(crq_pkg::FRAME_LEN)) begin
			frame_byte = frame_q[fidx_q[$clog2(crq_pkg::FRAME_LEN)-1:0]];
		end
	end

	always_comb begin
		emit   = 1'b0;
		e_kind = crq_pkg::RES_TX;
		e_tx   = 8'd0;
		e_word = 16'd0;
		e_idx  = 4'd0;
		e_last = 1'b0;
		case (state_q)
			ST_SEND: begin
				emit   = out_free;
				e_tx   = frame_byte;
				e_last = (fidx_q == crq_pkg::FIDX_W'(crq_pkg::FRAME_LEN));
			end
			ST_RESTART: begin
				emit   = out_free;
				e_kind = crq_pkg::RES_RESTART;
			end
			ST_WORDS: begin
				emit   = out_free;
				e_kind = crq_pkg::RES_WORD;
				e_word = store_q[widx_q];
				e_idx  = 4'(widx_q);
			end
			ST_DONE: begin
				emit   = out_free;
				e_kind = crq_pkg::RES_DONE;
				e_last = 1'b1;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	// payload stores
	always_ff @(posedge clk) begin
		if (is_req) begin
			frame_q[0] <= (cmd.kind == crq_pkg::KIND_READ) ? crq_pkg::CMD_READ :
				crq_pkg::CMD_WRITE;
			frame_q[1] <= cmd.addr[7:0];
			frame_q[2] <= cmd.addr[15:8];
			frame_q[3] <= (cmd.kind == crq_pkg::KIND_READ) ? 8'(cmd.cnt) : cmd.wval[7:0];
			frame_q[4] <= (cmd.kind == crq_pkg::KIND_READ) ? 8'd0 : cmd.wval[15:8];
		end
		if (store_we) begin
			store_q[wsel] <= {cmd.rxb, low_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			awaiting_q <= 1'b0;
			is_read_q  <= 1'b0;
			cnt_q      <= '0;
			rx_pos_q   <= '0;
			rx_crc_q   <= 8'd0;
			echo_q     <= 1'b1;
			low_q      <= 8'd0;
			failed_q   <= 16'd0;
			wait_q     <= 16'd0;
			fidx_q     <= '0;
			widx_q     <= '0;
			tx_crc_q   <= 8'd0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (is_req) begin
						is_read_q  <= (cmd.kind == crq_pkg::KIND_READ);
						cnt_q      <= cmd.cnt;
						failed_q   <= 16'd0;
						awaiting_q <= 1'b0;
						fidx_q     <= '0;
						tx_crc_q   <= 8'd0;
						state_q    <= ST_SEND;
					end else if (fail_go) begin
						failed_q <= over_limit ? 16'd0 : failed_inc;
						fidx_q   <= '0;
						tx_crc_q <= 8'd0;
						state_q  <= over_limit ? ST_RESTART : ST_SEND;
					end else if (tick_go) begin
						wait_q <= wait_inc;
					end else if (rx_go && !last_byte) begin
						rx_crc_q <= crq_pkg::crc8_step(rx_crc_q, cmd.rxb);
						if ((rx_pos_q == crq_pkg::POS_W'(1) && cmd.rxb != frame_q[1]) ||
						    (rx_pos_q == crq_pkg::POS_W'(2) && cmd.rxb != frame_q[2])) begin
							echo_q <= 1'b0;
						end
						if (is_read_q && !(rx_pos_q < crq_pkg::POS_W'(4)) && !rx_pos_q[0]) begin
							low_q <= cmd.rxb;
						end
						rx_pos_q <= pos_inc;
					end else if (rx_go) begin
						awaiting_q <= 1'b0;
						rx_pos_q   <= '0;
						rx_crc_q   <= 8'd0;
						echo_q     <= 1'b1;
						failed_q   <= 16'd0;
						wait_q     <= 16'd0;
						widx_q     <= '0;
						state_q    <= (is_read_q && cnt_q != '0) ? ST_WORDS : ST_DONE;
					end
				end
				ST_SEND: begin
					if (emit) begin
						tx_crc_q <= crq_pkg::crc8_step(tx_crc_q, frame_byte);
						fidx_q   <= fidx_q + crq_pkg::FIDX_W'(1);
						if (e_last) begin
							awaiting_q <= 1'b1;
							rx_pos_q   <= '0;
							rx_crc_q   <= 8'd0;
							echo_q     <= 1'b1;
							low_q      <= 8'd0;
							wait_q     <= 16'd0;
							state_q    <= ST_IDLE;
						end
					end
				end
				ST_RESTART: begin
					if (emit) begin
						state_q <= ST_SEND;
					end
				end
				ST_WORDS: begin
					if (emit) begin
						widx_q <= widx_q + crq_pkg::WIDX_W'(1);
						if (words_end) begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_DONE: begin
					if (emit) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (emit) begin
			out_kind_q  <= e_kind;
			out_tx_q    <= e_tx;
			out_word_q  <= e_word;
			out_index_q <= e_idx;
			out_last_q  <= e_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_kind  = out_kind_q;
	assign out_tx    = out_tx_q;
	assign out_word  = out_word_q;
	assign out_index = out_index_q;
	assign out_last  = out_last_q;

	`CRQ_ASSERT_NOW(a_words_in_read, state_q == ST_WORDS,
		is_read_q && (crq_pkg::CNT_W'(widx_q) < cnt_q), "word output outside a read")
	`CRQ_ASSERT_NOW(a_pos_bound, awaiting_q, rx_pos_q < total,
		"response position past frame end")
	`CRQ_ASSERT_NEXT(a_send_arms,
		state_q == ST_SEND && emit && e_last,
		awaiting_q && rx_pos_q == '0 && state_q == ST_IDLE, "frame end did not arm receive")
	`CRQ_ASSERT_NOW(a_restart_clear, state_q == ST_RESTART, failed_q == 16'd0,
		"retry count not cleared on restart")

endmodule

// ===== src/crc8_register_access_requester.sv =====
// Top level of the CRC-8 framed register access requester: config registers and wiring.
// Depends on crq_pkg, crq_front and crq_back.
//
//  channel | dir | handshake          | payload
//  s_*     | in  | s_tvalid/s_tready  | tuser kind, tdata request fields / rx byte
//  m_*     | out | m_tvalid/m_tready  | tuser result kind, tdata tx/word/index, tlast
//  cfg_*   | in  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// The back end takes a received byte or tick while idle; a request sends six frame bytes
// (one per cycle out of the output register unless stalled); an accepted read n words, then done.
// A two-entry command queue lets input items keep arriving while frames are sent.
// Reset is asynchronous and clears all control state; no clearing pass is needed.
// Stalls on m_tready hold the back end; a full queue drops s_tready.
module crc8_register_access_requester (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [1:0]  s_tuser,   // kind
	input  logic [55:0] s_tdata,   // param_address, word_count, write_value, rx_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [1:0]  m_tuser,   // result_kind
	output logic [31:0] m_tdata,   // tx_byte, read_word, word_index, zero pad
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	logic [15:0]         timeout_q;
	logic [15:0]         retry_q;
	logic                cmd_valid;
	crq_pkg::cmd_t       cmd;
	logic                cmd_pop;
	crq_pkg::res_kind_t  res_kind;
	logic [7:0]          res_tx;
	logic [15:0]         res_word;
	logic [3:0]          res_index;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= crq_pkg::TIMEOUT_RESET;
			retry_q   <= crq_pkg::RETRY_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				crq_pkg::REG_RESPONSE_TIMEOUT: timeout_q <= cfg_data;
				crq_pkg::REG_RETRY_LIMIT: retry_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	crq_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_kind   (s_tuser),
		.in_addr   (s_tdata[15:0]),
		.in_count  (s_tdata[31:16]),
		.in_wval   (s_tdata[47:32]),
		.in_rxb    (s_tdata[55:48]),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	crq_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd_valid        (cmd_valid),
		.cmd              (cmd),
		.cmd_pop          (cmd_pop),
		.response_timeout (timeout_q),
		.retry_limit      (retry_q),
		.out_valid        (m_tvalid),
		.out_ready        (m_tready),
		.out_kind         (res_kind),
		.out_tx           (res_tx),
		.out_word         (res_word),
		.out_index        (res_index),
		.out_last         (m_tlast)
	);

	assign m_tuser = res_kind;
	assign m_tdata = {4'd0, res_index, res_word, res_tx};

endmodule

// ===== tb/crc8_register_access_requester_tb.sv =====
// Self-checking testbench for the CRC-8 framed register access requester: request, response
// byte and tick items with random gaps and output stalls, checked against a protocol predictor.
// Depends on crq_pkg and crc8_register_access_requester.
`timescale 1ns / 100ps

module crc8_register_access_requester_tb;

	typedef struct {
		crq_pkg::kind_t kind;
		logic [15:0]    addr;
		logic [15:0]    cnt;
		logic [15:0]    wval;
		logic [7:0]     rxb;
	} link_item_t;

	typedef struct packed {
		crq_pkg::res_kind_t kind;
		logic [7:0]         txb;
		logic [15:0]        word;
		logic [3:0]         idx;
		logic               last;
	} link_result_t;

	typedef enum logic [1:0] {
		REPLY_GOOD,
		REPLY_BAD_CRC,
		REPLY_BAD_ECHO,
		REPLY_PARTIAL
	} reply_mode_t;

	typedef struct packed {
		bit             is_reply;
		reply_mode_t    mode;
		crq_pkg::kind_t kind;
		logic [15:0]    addr;
		logic [15:0]    cnt;
		logic [15:0]    wval;
		logic [7:0]     rxb;
		int             exp_n;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [1:0]  s_tuser;
	logic [55:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [1:0]  m_tuser;
	logic [31:0] m_tdata;
	logic        m_tlast;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;

	crc8_register_access_requester u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tuser   (m_tuser),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// predictor state
	logic [15:0] tmo_cfg;
	logic [15:0] retry_cfg;
	bit          busy;
	bit          is_read;
	logic [7:0]  frame [0:4];
	logic [4:0]  nwords;
	logic [5:0]  rx_pos;
	logic [7:0]  crc_run;
	bit          echo_ok;
	logic [7:0]  lo_hold;
	logic [15:0] words [0:15];
	logic [15:0] fail_cnt;
	logic [15:0] tick_cnt;

	link_result_t staged [$];
	link_result_t exp_q [$];
	link_result_t got;
	link_result_t want;
	int           last_n;

	int  err_cnt = 0;
	int  items_sent = 0;
	int  n_items = 0;
	int  n_out = 0;
	int  n_words = 0;
	int  n_done = 0;
	int  n_restarts = 0;
	int  quiet = 0;
	int  burst_left = 4;
	bit  steady = 0;
	logic [5:0]  pat_pos = '0;
	logic [15:0] stall_pat = 16'hFFFF;

	dir_row_t dir_rows [0:8] = '{
		'{1'b0, REPLY_GOOD, crq_pkg::KIND_RX, 16'h1234, 16'h0000, 16'h0000, 8'h00, 0},
		'{1'b0, REPLY_GOOD, crq_pkg::KIND_TICK, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 0},
		'{1'b0, REPLY_GOOD, crq_pkg::KIND_READ, 16'hFFFF, 16'h0000, 16'hFFFF, 8'hFF, 6},
		'{1'b1, REPLY_GOOD, crq_pkg::KIND_RX, 16'h0000, 16'h0000, 16'h0000, 8'h00, -1},
		'{1'b0, REPLY_GOOD, crq_pkg::KIND_READ, 16'h0000, 16'hFFFF, 16'h0000, 8'h00, 6},
		'{1'b0, REPLY_GOOD, crq_pkg::KIND_WRITE, 16'h00FF, 16'h0000, 16'hFFFF, 8'h00, 6},
		'{1'b1, REPLY_BAD_CRC, crq_pkg::KIND_RX, 16'h0000, 16'h0000, 16'h0000,
			crq_pkg::CMD_WRITE, -1},
		'{1'b0, REPLY_GOOD, crq_pkg::KIND_READ, 16'h5AA5, 16'h0001, 16'h0000, 8'h00, 6},
		'{1'b1, REPLY_GOOD, crq_pkg::KIND_RX, 16'h0000, 16'h0000, 16'h0000,
			crq_pkg::CMD_READ, -1}
	};

	always #6 clk = ~clk;

	function automatic logic [7:0] crc8_next(logic [7:0] c, logic [7:0] d);
		logic fb;
		for (int i = 0; i < 8; i++) begin
			fb = c[0] ^ d[i];
			c = c >> 1;
			if (fb) begin
				c = c ^ crq_pkg::CRC_POLY;
			end
		end
		return c;
	endfunction

	function automatic string fmt_result(link_result_t r);
		return $sformatf("kind=%0d tx=%02h word=%04h idx=%0d last=%0b",
			r.kind, r.txb, r.word, r.idx, r.last);
	endfunction

	function automatic link_item_t noise_item(crq_pkg::kind_t k);
		link_item_t it;
		it.kind = k;
		it.addr = 16'($urandom);
		it.cnt  = 16'($urandom);
		it.wval = 16'($urandom);
		it.rxb  = 8'($urandom);
		return it;
	endfunction

	function automatic logic [7:0] pick_cmd();
		return ($urandom_range(0, 4) == 0) ? 8'($urandom) : frame[0];
	endfunction

	function void emit(crq_pkg::res_kind_t k, logic [7:0] t, logic [15:0] w, logic [3:0] i);
		staged.push_back('{k, t, w, i, 1'b0});
	endfunction

	task automatic flag_error(input string msg);
		err_cnt++;
		if (err_cnt <= 10) begin
			$display("%0t: %s", $realtime, msg);
		end
	endtask

	task automatic transmit_frame();
		logic [7:0] c;
		c = 8'h00;
		for (int i = 0; i < 5; i++) begin
			c = crc8_next(c, frame[3'(i)]);
			emit(crq_pkg::RES_TX, frame[3'(i)], 16'h0000, 4'h0);
		end
		emit(crq_pkg::RES_TX, c, 16'h0000, 4'h0);
		busy = 1'b1;
		rx_pos = '0;
		crc_run = 8'h00;
		echo_ok = 1'b1;
		lo_hold = 8'h00;
		tick_cnt = '0;
	endtask

	task automatic count_failure();
		fail_cnt = fail_cnt + 16'd1;
		if (fail_cnt > retry_cfg) begin
			fail_cnt = '0;
			emit(crq_pkg::RES_RESTART, 8'h00, 16'h0000, 4'h0);
		end
		transmit_frame();
	endtask

	task automatic predict_item(input link_item_t it);
		int total;
		logic [5:0] p;
		logic [5:0] pm4;
		staged.delete();
		if (it.kind == crq_pkg::KIND_READ || it.kind == crq_pkg::KIND_WRITE) begin
			is_read = (it.kind == crq_pkg::KIND_READ);
			frame[0] = is_read ? crq_pkg::CMD_READ : crq_pkg::CMD_WRITE;
			frame[1] = it.addr[7:0];
			frame[2] = it.addr[15:8];
			if (is_read) begin
				nwords = (it.cnt > crq_pkg::MAX_WORDS) ? 5'(crq_pkg::MAX_WORDS) : it.cnt[4:0];
				frame[3] = 8'(nwords);
				frame[4] = 8'h00;
			end else begin
				nwords = '0;
				frame[3] = it.wval[7:0];
				frame[4] = it.wval[15:8];
			end
			fail_cnt = '0;
			transmit_frame();
		end else if (busy && it.kind == crq_pkg::KIND_TICK) begin
			tick_cnt = tick_cnt + 16'd1;
			if (tick_cnt >= tmo_cfg) begin
				count_failure();
			end
		end else if (busy) begin
			total = is_read ? 5 + 2 * nwords : 6;
			p = rx_pos;
			if (p + 1 < total) begin
				crc_run = crc8_next(crc_run, it.rxb);
				if ((p == 1 || p == 2) && it.rxb != frame[p[2:0]]) begin
					echo_ok = 1'b0;
				end
				if (is_read && p >= 4) begin
					if (!p[0]) begin
						lo_hold = it.rxb;
					end else begin
						pm4 = p - 6'd4;
						words[pm4[4:1]] = {it.rxb, lo_hold};
					end
				end
				rx_pos = p + 6'd1;
			end else if (echo_ok && crc_run == it.rxb) begin
				for (int n = 0; n < nwords; n++) begin
					emit(crq_pkg::RES_WORD, 8'h00, words[4'(n)], 4'(n));
				end
				emit(crq_pkg::RES_DONE, 8'h00, 16'h0000, 4'h0);
				busy = 1'b0;
				rx_pos = '0;
				crc_run = 8'h00;
				echo_ok = 1'b1;
				fail_cnt = '0;
				tick_cnt = '0;
			end else begin
				count_failure();
			end
		end
		if (staged.size() > 0) begin
			staged[staged.size() - 1].last = 1'b1;
		end
		foreach (staged[i]) begin
			exp_q.push_back(staged[i]);
		end
		last_n = staged.size();
	endtask

	task automatic push_item(input link_item_t it);
		int gap;
		bit counted;
		s_tuser <= it.kind;
		s_tdata <= {it.rxb, it.wval, it.cnt, it.addr};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		counted = (it.kind == crq_pkg::KIND_READ || it.kind == crq_pkg::KIND_WRITE || busy);
		predict_item(it);
		n_items++;
		if (counted) begin
			items_sent++;
		end
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = steady ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end else begin
			burst_left--;
		end
	endtask

	task automatic send_reply(input reply_mode_t mode, input logic [7:0] cmd);
		logic [7:0] bytes [$];
		logic [7:0] c;
		link_item_t it;
		int total;
		int n_send;
		total = is_read ? 5 + 2 * nwords : 6;
		bytes.push_back(cmd);
		bytes.push_back(frame[1]);
		bytes.push_back(frame[2]);
		if (is_read) begin
			bytes.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'(nwords));
			repeat (2 * nwords) bytes.push_back(8'($urandom));
		end else begin
			bytes.push_back(frame[3]);
			bytes.push_back(frame[4]);
		end
		if (mode == REPLY_BAD_ECHO) begin
			bytes[$urandom_range(1, 2)] ^= 8'($urandom_range(1, 255));
		end
		c = 8'h00;
		foreach (bytes[i]) begin
			c = crc8_next(c, bytes[i]);
		end
		if (mode == REPLY_BAD_CRC) begin
			c ^= 8'($urandom_range(1, 255));
		end
		bytes.push_back(c);
		n_send = (mode == REPLY_PARTIAL) ? $urandom_range(1, total - 1) : total;
		for (int i = 0; i < n_send; i++) begin
			it = noise_item(crq_pkg::KIND_RX);
			it.rxb = bytes[i];
			push_item(it);
		end
	endtask

	task automatic pause_for_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (exp_q.size() != 0);
	endtask

	task automatic wait_quiet();
		pause_for_results();
		repeat (20) @(posedge clk);
	endtask

	// leaves cfg_valid high; the caller drops it after the last write
	task automatic write_reg(input crq_pkg::cfg_reg_t idx, input logic [15:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		if (idx == crq_pkg::REG_RESPONSE_TIMEOUT) begin
			tmo_cfg = val;
		end else begin
			retry_cfg = val;
		end
	endtask

	task automatic run_random(input int target);
		link_item_t it;
		int first_cnt;
		int pick;
		int outcome;
		int n_ticks;
		first_cnt = items_sent;
		while (items_sent - first_cnt < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				repeat ($urandom_range(1, 3)) begin
					push_item(noise_item(crq_pkg::kind_t'($urandom_range(0, 3))));
				end
			end else begin
				if (pick < 13) begin
					pause_for_results();
				end
				it = noise_item(($urandom_range(0, 2) == 0) ? crq_pkg::KIND_WRITE :
					crq_pkg::KIND_READ);
				if (it.kind == crq_pkg::KIND_READ) begin
					case ($urandom_range(0, 9))
						0: it.cnt = 16'($urandom);
						1: it.cnt = 16'($urandom_range(4, 16));
						default: it.cnt = 16'($urandom_range(0, 3));
					endcase
				end
				push_item(it);
				outcome = $urandom_range(0, 99);
				if (outcome < 45) begin
					send_reply(REPLY_GOOD, pick_cmd());
				end else if (outcome < 80) begin
					repeat ($urandom_range(1, 3)) begin
						case ($urandom_range(0, 2))
							0: send_reply(REPLY_BAD_CRC, pick_cmd());
							1: send_reply(REPLY_BAD_ECHO, pick_cmd());
							default: begin
								// ticks up to the timeout; long timeouts just see a couple
								n_ticks = (tmo_cfg <= 1) ? 1 : tmo_cfg;
								if (n_ticks > 8) begin
									n_ticks = 2;
								end
								repeat (n_ticks) push_item(noise_item(crq_pkg::KIND_TICK));
							end
						endcase
					end
					send_reply(REPLY_GOOD, pick_cmd());
				end else if (outcome < 92) begin
					send_reply(REPLY_PARTIAL, pick_cmd());
				end
			end
		end
	endtask

	// output stall pattern, reloaded each time pat_pos wraps
	always @(posedge clk) begin
		pat_pos <= pat_pos + 6'd1;
		if (pat_pos == 6'd63) begin
			case ($urandom_range(0, 4))
				0: stall_pat <= 16'hFFFF;
				1: stall_pat <= 16'($urandom);
				2: stall_pat <= 16'h0101;
				3: stall_pat <= 16'h0001;
				default: stall_pat <= 16'hF0F3;
			endcase
		end
		m_tready <= stall_pat[pat_pos[3:0]];
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got.kind = crq_pkg::res_kind_t'(m_tuser);
			got.txb = m_tdata[7:0];
			got.word = m_tdata[23:8];
			got.idx = m_tdata[27:24];
			got.last = m_tlast;
			n_out++;
			if (got.kind == crq_pkg::RES_WORD) n_words++;
			if (got.kind == crq_pkg::RES_DONE) n_done++;
			if (got.kind == crq_pkg::RES_RESTART) n_restarts++;
			if (exp_q.size() == 0) begin
				flag_error({"unexpected item: ", fmt_result(got)});
			end else begin
				want = exp_q.pop_front();
				if (got !== want) begin
					flag_error({"expected ", fmt_result(want), " got ", fmt_result(got)});
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
		end
		if (quiet >= 3000) begin
			$display("watchdog: no handshake for %0d cycles", quiet);
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tuser = '0;
		s_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		tmo_cfg = crq_pkg::TIMEOUT_RESET;
		retry_cfg = crq_pkg::RETRY_RESET;
		busy = 1'b0;
		is_read = 1'b0;
		nwords = '0;
		rx_pos = '0;
		crc_run = 8'h00;
		echo_ok = 1'b1;
		lo_hold = 8'h00;
		fail_cnt = '0;
		tick_cnt = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: idle items, field extremes, saturation, abandon, bad CRC, word read
		foreach (dir_rows[i]) begin
			if (dir_rows[i].is_reply) begin
				send_reply(dir_rows[i].mode, dir_rows[i].rxb);
			end else begin
				push_item('{dir_rows[i].kind, dir_rows[i].addr, dir_rows[i].cnt,
					dir_rows[i].wval, dir_rows[i].rxb});
				if (dir_rows[i].exp_n >= 0 && last_n != dir_rows[i].exp_n) begin
					flag_error($sformatf("row %0d: %0d items predicted, table says %0d",
						i, last_n, dir_rows[i].exp_n));
				end
			end
		end

		for (int ph = 0; ph < 5; ph++) begin
			wait_quiet();
			case (ph)
				0: begin
					write_reg(crq_pkg::REG_RESPONSE_TIMEOUT, 16'd1);
					write_reg(crq_pkg::REG_RETRY_LIMIT, 16'd0);
				end
				1: begin
					write_reg(crq_pkg::REG_RESPONSE_TIMEOUT, 16'd3);
					write_reg(crq_pkg::REG_RETRY_LIMIT, 16'd2);
				end
				2: begin
					write_reg(crq_pkg::REG_RESPONSE_TIMEOUT, 16'hFFFF);
					write_reg(crq_pkg::REG_RETRY_LIMIT, 16'hFFFF);
				end
				3: begin
					write_reg(crq_pkg::REG_RESPONSE_TIMEOUT, 16'd0);
					write_reg(crq_pkg::REG_RETRY_LIMIT, 16'd1);
				end
				default: begin
					write_reg(crq_pkg::REG_RESPONSE_TIMEOUT, 16'($urandom_range(1, 6)));
					write_reg(crq_pkg::REG_RETRY_LIMIT, 16'($urandom_range(0, 5)));
				end
			endcase
			cfg_valid <= 1'b0;
			steady = (ph == 2);
			run_random(12);
		end

		wait_quiet();
		$display("%0d items sent (%0d while a request was open), %0d results checked",
			n_items, items_sent, n_out);
		$display("%0d read words, %0d requests done, %0d link restarts, 5 timeout/retry settings",
			n_words, n_done, n_restarts);
		if (err_cnt == 0) begin
			$display("TB_OK");
		end else begin
			$display("%0d mismatches", err_cnt);
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
